[sv/pmd_pkg.sv]
// Shared types, codes and helper functions for the pushbuffer method decoder.
package pmd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned ADDR_W = 12;
    localparam int unsigned INDEX_W = 14;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned SUB_W = 3;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned CFG_W = 12;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_REG_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_END = 1'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] HOST_REG_COUNT_RESET = 12'd64;
    localparam logic [CFG_W-1:0] ENGINE_END_RESET = 12'd3584;

    // Header operation codes (bits 31..29).
    localparam logic [2:0] OP_GRP0 = 3'd0;
    localparam logic [2:0] OP_INC = 3'd1;
    localparam logic [2:0] OP_NONINC = 3'd3;
    localparam logic [2:0] OP_IMMD = 3'd4;
    localparam logic [2:0] OP_ONEINC = 3'd5;
    localparam logic [2:0] OP_ENDSEG = 3'd7;

    // Tertiary operation of group 0 (bits 18..16).
    localparam logic [2:0] TERT_SET_SUBDEV_MASK = 3'd1;

    // Subchannels that accept macro arguments.
    localparam logic [SUB_W-1:0] SUB_3D = 3'd0;
    localparam logic [SUB_W-1:0] SUB_2D = 3'd3;

    // Call classes.
    localparam logic [KIND_W-1:0] KIND_HOST_REG = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENGINE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MACRO_ARG = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UNROUTABLE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNSUPPORTED = 3'd4;

    typedef enum logic [1:0] {
        MODE_INC    = 2'd0,
        MODE_NONINC = 2'd1,
        MODE_ONEINC = 2'd2
    } t_mode;

    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [SUB_W-1:0]    subchannel;
        logic [INDEX_W-1:0]  method_index;
        logic [WORD_W-1:0]   argument;
        logic                method_last;
    } t_result;

    typedef struct packed {
        logic skip_rest;
        logic method_open;
    } t_status;

    // Classes a call by its method index; the host range wins on overlap.
    function automatic logic [KIND_W-1:0] classify(
        input logic [INDEX_W-1:0] index,
        input logic [SUB_W-1:0]   sub,
        input logic [CFG_W-1:0]   host_reg_count,
        input logic [CFG_W-1:0]   engine_end
    );
        logic [KIND_W-1:0] kind;
        if (index < {2'b00, host_reg_count}) begin
            kind = KIND_HOST_REG;
        end else if (index < {2'b00, engine_end}) begin
            kind = KIND_ENGINE;
        end else if (sub == SUB_3D || sub == SUB_2D) begin
            kind = KIND_MACRO_ARG;
        end else begin
            kind = KIND_UNROUTABLE;
        end
        return kind;
    endfunction

endpackage

[sv/pmd_decode.sv]
// Header decode, open-method state and call generation for one command word.
module pmd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [pmd_pkg::WORD_W-1:0]    i_word,
    input  logic                          i_entry_last,
    input  logic [pmd_pkg::CFG_W-1:0]     i_host_reg_count,
    input  logic [pmd_pkg::CFG_W-1:0]     i_engine_end,
    output pmd_pkg::t_result              o_result,
    output pmd_pkg::t_status              o_status
);
    import pmd_pkg::*;

    logic [COUNT_W-1:0] r_remaining, n_remaining;
    logic [INDEX_W-1:0] r_next_addr, n_next_addr;
    logic [SUB_W-1:0]   r_open_sub, n_open_sub;
    t_mode              r_mode, n_mode;
    logic               r_skip, n_skip;

    logic [2:0]         hdr_op;
    logic [ADDR_W-1:0]  hdr_addr;
    logic [SUB_W-1:0]   hdr_sub;
    logic [COUNT_W-1:0] hdr_count;
    logic [2:0]         hdr_tert;
    logic [COUNT_W-1:0] rem_dec;

    assign hdr_op    = i_word[31:29];
    assign hdr_addr  = i_word[11:0];
    assign hdr_sub   = i_word[15:13];
    assign hdr_count = i_word[28:16];
    assign hdr_tert  = i_word[18:16];
    assign rem_dec   = r_remaining - 1'b1;

    always_comb begin
        n_remaining = r_remaining;
        n_next_addr = r_next_addr;
        n_open_sub  = r_open_sub;
        n_mode      = r_mode;
        n_skip      = r_skip;
        o_result    = '0;

        if (r_skip) begin
            if (i_entry_last) begin
                n_skip = 1'b0;
            end
        end else if (r_remaining != '0) begin
            // Data word of an open method.
            n_remaining           = rem_dec;
            o_result.valid        = 1'b1;
            o_result.kind         = classify(r_next_addr, r_open_sub,
                                             i_host_reg_count, i_engine_end);
            o_result.subchannel   = r_open_sub;
            o_result.method_index = r_next_addr;
            o_result.argument     = i_word;
            o_result.method_last  = (rem_dec == '0);
            unique case (r_mode)
                MODE_INC: begin
                    n_next_addr = r_next_addr + 1'b1;
                end
                MODE_ONEINC: begin
                    n_next_addr = r_next_addr + 1'b1;
                    n_mode      = MODE_NONINC;
                end
                default: begin
                    n_next_addr = r_next_addr;
                end
            endcase
        end else if (i_word != '0) begin
            unique case (hdr_op)
                OP_INC, OP_NONINC, OP_ONEINC: begin
                    if (hdr_count != '0) begin
                        n_remaining = hdr_count;
                        n_next_addr = {2'b00, hdr_addr};
                        n_open_sub  = hdr_sub;
                        n_mode      = (hdr_op == OP_INC) ? MODE_INC :
                                      (hdr_op == OP_NONINC) ? MODE_NONINC : MODE_ONEINC;
                    end
                end
                OP_IMMD: begin
                    o_result.valid        = 1'b1;
                    o_result.kind         = classify({2'b00, hdr_addr}, hdr_sub,
                                                     i_host_reg_count, i_engine_end);
                    o_result.subchannel   = hdr_sub;
                    o_result.method_index = {2'b00, hdr_addr};
                    o_result.argument     = {{(WORD_W-COUNT_W){1'b0}}, hdr_count};
                    o_result.method_last  = 1'b1;
                end
                OP_ENDSEG: begin
                    n_skip = !i_entry_last;
                end
                default: begin
                    // The subdevice mask is ignored; anything else is unsupported.
                    if (!(hdr_op == OP_GRP0 && hdr_tert == TERT_SET_SUBDEV_MASK)) begin
                        o_result.valid        = 1'b1;
                        o_result.kind         = KIND_UNSUPPORTED;
                        o_result.subchannel   = hdr_sub;
                        o_result.method_index = {2'b00, hdr_addr};
                        o_result.argument     = i_word;
                        o_result.method_last  = 1'b1;
                        n_skip                = !i_entry_last;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_next_addr <= '0;
            r_open_sub  <= '0;
            r_mode      <= MODE_INC;
            r_skip      <= 1'b0;
        end else if (i_step) begin
            r_remaining <= n_remaining;
            r_next_addr <= n_next_addr;
            r_open_sub  <= n_open_sub;
            r_mode      <= n_mode;
            r_skip      <= n_skip;
        end
    end

    assign o_status.skip_rest   = r_skip;
    assign o_status.method_open = (r_remaining != '0);

endmodule

[sv/pushbuffer_method_decoder.sv]
// Top level of the pushbuffer method decoder: beat registers, configuration and checks.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_word, i_entry_last
//   output    out        o_out_valid / i_out_stall  o_kind, o_subchannel, o_method_index,
//                                                   o_argument, o_method_last
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Every beat passes the input and then the output register, and one beat is accepted
// per cycle as long as the output side keeps up. The input register feeds the decode
// logic, whose call is captured in the output register; the state update happens as
// the beat leaves the input register. A beat that yields no call still passes through.
// Reset is synchronous and active low; it restores the configuration defaults and
// closes any open method. An output stall while a call waits holds both registers.
module pushbuffer_method_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pmd_pkg::WORD_W-1:0]    i_word,
    input  logic                          i_entry_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pmd_pkg::KIND_W-1:0]    o_kind,
    output logic [pmd_pkg::SUB_W-1:0]     o_subchannel,
    output logic [pmd_pkg::INDEX_W-1:0]   o_method_index,
    output logic [pmd_pkg::WORD_W-1:0]    o_argument,
    output logic                          o_method_last,
    input  logic                          i_cfg_we,
    input  logic [pmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pmd_pkg::CFG_W-1:0]     i_cfg_data
);
    import pmd_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] r_host_reg_count;
    logic [CFG_W-1:0] r_engine_end;

    // Input beat register.
    logic              r_in_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_entry_last;

    // Output beat register.
    t_result r_out;

    t_result dec_result;
    t_status dec_status;
    logic    out_ready;
    logic    step;

    // The output register can take a new value when empty or being drained.
    assign out_ready  = !r_out.valid || !i_out_stall;
    assign step       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_reg_count <= HOST_REG_COUNT_RESET;
            r_engine_end     <= ENGINE_END_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HOST_REG_COUNT: r_host_reg_count <= i_cfg_data;
                CFG_ENGINE_END:     r_engine_end     <= i_cfg_data;
                default:            r_engine_end     <= r_engine_end;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_word       <= i_word;
            r_entry_last <= i_entry_last;
        end
    end

    pmd_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_word           (r_word),
        .i_entry_last     (r_entry_last),
        .i_host_reg_count (r_host_reg_count),
        .i_engine_end     (r_engine_end),
        .o_result         (dec_result),
        .o_status         (dec_status)
    );

    // The valid bit is control state; the rest of the call is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (out_ready) begin
            r_out.valid <= step && dec_result.valid;
        end
        if (step && dec_result.valid) begin
            r_out.kind         <= dec_result.kind;
            r_out.subchannel   <= dec_result.subchannel;
            r_out.method_index <= dec_result.method_index;
            r_out.argument     <= dec_result.argument;
            r_out.method_last  <= dec_result.method_last;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_kind         = r_out.kind;
    assign o_subchannel   = r_out.subchannel;
    assign o_method_index = r_out.method_index;
    assign o_argument     = r_out.argument;
    assign o_method_last  = r_out.method_last;

`ifndef SYNTHESIS
    // A method is never open while the rest of an entry is being skipped.
    a_skip_excludes_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dec_status.skip_rest && dec_status.method_open))
        else $error("skip and open method at the same time");

    // An unsupported header always closes its own sequence.
    a_unsupported_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_UNSUPPORTED) |-> o_method_last)
        else $error("unsupported header call without method_last");

    // Unroutable macro calls only come from subchannels other than 3D and 2D.
    a_unroutable_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_UNROUTABLE) |->
            (o_subchannel != SUB_3D && o_subchannel != SUB_2D))
        else $error("unroutable call on a macro-capable subchannel");

    // The input side only stalls while a beat is held in the input register.
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out.valid))
        else $error("input stalled without a held beat");
`endif

endmodule

[tb/pushbuffer_method_decoder_tb.sv]
// Self-checking testbench for the pushbuffer method decoder with its own decode model.
module pushbuffer_method_decoder_tb;
    import pmd_pkg::*;

    // Group 0 (but for the subdevice mask) and the reserved operations 2 and 6 are rejected as unsupported headers.
    localparam logic [2:0] OP_RSVD2 = 3'd2;
    localparam logic [2:0] OP_RSVD6 = 3'd6;

    // One call as it leaves the block, without the handshake.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SUB_W-1:0]   subchannel;
        logic [INDEX_W-1:0] method_index;
        logic [WORD_W-1:0]  argument;
        logic               method_last;
    } t_call;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [WORD_W-1:0]    i_word;
    logic                 i_entry_last;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [KIND_W-1:0]    o_kind;
    logic [SUB_W-1:0]     o_subchannel;
    logic [INDEX_W-1:0]   o_method_index;
    logic [WORD_W-1:0]    o_argument;
    logic                 o_method_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Decode state kept by the testbench, updated on every accepted input beat.
    logic [COUNT_W-1:0]   pend_count;
    logic [INDEX_W-1:0]   call_addr;
    logic [SUB_W-1:0]     open_sub;
    t_mode                addr_mode;
    logic                 skipping;
    logic [CFG_W-1:0]     host_limit;
    logic [CFG_W-1:0]     engine_limit;
    t_call                expected_calls[$];

    int                   fail_count = 0;
    int                   beats_sent = 0;
    int                   hold_cycles = 0;
    int                   burst_left = 0;
    bit                   tx_idle_en;
    bit                   rx_idle_en;

    pushbuffer_method_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_word         (i_word),
        .i_entry_last   (i_entry_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_subchannel   (o_subchannel),
        .o_method_index (o_method_index),
        .o_argument     (o_argument),
        .o_method_last  (o_method_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decode model
    // ------------------------------------------------------------------

    function automatic t_call make_call(input logic [KIND_W-1:0] kind,
                                        input logic [SUB_W-1:0] sub,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic [WORD_W-1:0] arg,
                                        input logic last);
        t_call c;
        c.kind         = kind;
        c.subchannel   = sub;
        c.method_index = idx;
        c.argument     = arg;
        c.method_last  = last;
        return c;
    endfunction

    // The host range is tested first, so it wins when the two ranges overlap.
    function automatic logic [KIND_W-1:0] call_class(input logic [INDEX_W-1:0] idx,
                                                     input logic [SUB_W-1:0] sub);
        if (idx < {2'b00, host_limit}) return KIND_HOST_REG;
        if (idx < {2'b00, engine_limit}) return KIND_ENGINE;
        if (sub == SUB_3D || sub == SUB_2D) return KIND_MACRO_ARG;
        return KIND_UNROUTABLE;
    endfunction

    // Works out what one accepted beat does to the state and queues the call it yields.
    task automatic decode_word(input logic [WORD_W-1:0] w, input logic last);
        logic [2:0]         op;
        logic [2:0]         tert;
        logic [SUB_W-1:0]   sub;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
        op   = w[31:29];
        cnt  = w[28:16];
        tert = w[18:16];
        sub  = w[15:13];
        addr = w[11:0];
        if (skipping) begin
            // Words are thrown away up to and including the end of the entry.
            if (last) skipping = 1'b0;
        end else if (pend_count != '0) begin
            // Data word of the open method; the count survives entry boundaries.
            pend_count = pend_count - 1'b1;
            expected_calls.push_back(make_call(call_class(call_addr, open_sub), open_sub,
                                               call_addr, w, pend_count == '0));
            if (addr_mode == MODE_INC) begin
                call_addr = call_addr + 1'b1;
            end else if (addr_mode == MODE_ONEINC) begin
                call_addr = call_addr + 1'b1;
                addr_mode = MODE_NONINC;
            end
        end else if (w == '0) begin
            // A zero word between methods is a no-op.
        end else if (op == OP_INC || op == OP_NONINC || op == OP_ONEINC) begin
            // A header with a zero count opens nothing.
            if (cnt != '0) begin
                pend_count = cnt;
                call_addr  = {2'b00, addr};
                open_sub   = sub;
                if (op == OP_INC) addr_mode = MODE_INC;
                else if (op == OP_NONINC) addr_mode = MODE_NONINC;
                else addr_mode = MODE_ONEINC;
            end
        end else if (op == OP_IMMD) begin
            expected_calls.push_back(make_call(call_class({2'b00, addr}, sub), sub,
                                               {2'b00, addr}, {19'd0, cnt}, 1'b1));
        end else if (op == OP_ENDSEG) begin
            if (!last) skipping = 1'b1;
        end else if (!(op == OP_GRP0 && tert == TERT_SET_SUBDEV_MASK)) begin
            // Unsupported header: reported with the raw word, then the entry is dropped.
            expected_calls.push_back(make_call(KIND_UNSUPPORTED, sub, {2'b00, addr}, w, 1'b1));
            if (!last) skipping = 1'b1;
        end
    endtask

    task automatic log_error(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Monitor: input beats feed the model, output beats are checked in order.
    // Both handshakes are sampled at the rising edge, before any update of that edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_call got;
        t_call want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall === 1'b0) decode_word(i_word, i_entry_last);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                got = make_call(o_kind, o_subchannel, o_method_index, o_argument,
                                o_method_last);
                if (expected_calls.size() == 0) begin
                    log_error($sformatf("unexpected call: kind %0d sub %0d index %0d arg %h last %0d",
                                        got.kind, got.subchannel, got.method_index,
                                        got.argument, got.method_last));
                end else begin
                    want = expected_calls.pop_front();
                    if (got !== want) begin
                        log_error($sformatf({"call mismatch (expected/actual): kind %0d/%0d ",
                                             "sub %0d/%0d index %0d/%0d arg %h/%h last %0d/%0d"},
                                            want.kind, got.kind, want.subchannel,
                                            got.subchannel, want.method_index,
                                            got.method_index, want.argument, got.argument,
                                            want.method_last, got.method_last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stall bursts, or a long hold when asked.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left = burst_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one beat, sometimes after an idle burst, and returns at the edge that takes it.
    task automatic send_beat(input logic [WORD_W-1:0] w, input logic last);
        int unsigned gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_word       <= w;
        i_entry_last <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        beats_sent++;
    endtask

    // Stops offering beats and waits for every queued call plus the pipeline latency.
    task automatic wait_idle();
        int unsigned waited;
        int unsigned moving;
        i_in_valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (expected_calls.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        // Beats that yield no call may still sit in the pipeline behind an output stall.
        moving = 0;
        while (moving < 4) begin
            @(posedge i_clk);
            if (!i_out_stall) moving++;
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_HOST_REG_COUNT) host_limit = val;
        else engine_limit = val;
    endtask

    function automatic logic [WORD_W-1:0] make_header(input logic [2:0] op,
                                                      input logic [COUNT_W-1:0] cnt,
                                                      input logic [SUB_W-1:0] sub,
                                                      input logic [ADDR_W-1:0] addr);
        // Bit 12 is unused by the decode, so it gets a random value.
        return {op, cnt, sub, 1'($urandom), addr};
    endfunction

    // Method addresses cluster around the class boundaries half of the time.
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] off;
        off = ADDR_W'($urandom_range(0, 5)) - 12'd3;
        case ($urandom_range(0, 3))
            0: return host_limit + off;
            1: return engine_limit + off;
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_data();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic rand_last();
        return $urandom_range(0, 3) == 0;
    endfunction

    // After a header that drops the rest of its entry, sends the words that get dropped.
    task automatic send_skipped_tail(input logic hdr_last);
        if (!hdr_last) begin
            repeat ($urandom_range(0, 3)) send_beat(rand_data(), 1'b0);
            send_beat(rand_data(), 1'b1);
        end
    endtask

    // One well-formed command with random content, or now and then a stray word.
    task automatic play_sequence();
        int unsigned pick;
        int unsigned n;
        logic [2:0]  op;
        logic [2:0]  tert;
        logic        hdr_last;
        pick     = $urandom_range(0, 99);
        hdr_last = rand_last();
        if (pick < 55) begin
            case ($urandom_range(0, 2))
                0: op = OP_INC;
                1: op = OP_NONINC;
                default: op = OP_ONEINC;
            endcase
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 6);
            send_beat(make_header(op, COUNT_W'(n), SUB_W'($urandom), pick_addr()), hdr_last);
            repeat (n) send_beat(rand_data(), rand_last());
        end else if (pick < 70) begin
            send_beat(make_header(OP_IMMD, COUNT_W'($urandom), SUB_W'($urandom), pick_addr()),
                      hdr_last);
        end else if (pick < 75) begin
            send_beat('0, hdr_last);
        end else if (pick < 80) begin
            send_beat({OP_GRP0, 10'($urandom), TERT_SET_SUBDEV_MASK, 16'($urandom)}, hdr_last);
        end else if (pick < 90) begin
            case ($urandom_range(0, 2))
                0: begin
                    // Any tertiary operation other than the subdevice mask.
                    tert = 3'($urandom_range(0, 6));
                    if (tert >= TERT_SET_SUBDEV_MASK) tert = tert + 1'b1;
                    send_beat({OP_GRP0, 10'($urandom), tert, 16'($urandom)}, hdr_last);
                end
                1: send_beat({OP_RSVD2, 29'($urandom)}, hdr_last);
                default: send_beat({OP_RSVD6, 29'($urandom)}, hdr_last);
            endcase
            send_skipped_tail(hdr_last);
        end else begin
            send_beat({OP_ENDSEG, 29'($urandom)}, hdr_last);
            send_skipped_tail(hdr_last);
        end
    endtask

    task automatic run_beats(input int n);
        int target;
        target = beats_sent + n;
        while (beats_sent < target) play_sequence();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked beats under the reset configuration: every header kind and the corners.
    task automatic test_directed();
        send_beat('0, 1'b0);
        send_beat({OP_GRP0, 10'h3FF, TERT_SET_SUBDEV_MASK, 16'hFFFF}, 1'b0);
        // Incrementing method across the host boundary and across an entry end.
        send_beat(make_header(OP_INC, 13'd3, SUB_3D, 12'd62), 1'b0);
        send_beat('0, 1'b0);
        send_beat('1, 1'b1);
        send_beat(32'h1234_5678, 1'b0);
        // Increment-once from the top address: the index goes past 12 bits.
        send_beat(make_header(OP_ONEINC, 13'd3, SUB_2D, 12'hFFF), 1'b0);
        repeat (3) send_beat(rand_data(), 1'b0);
        // Non-incrementing macro calls on a subchannel that cannot take them.
        send_beat(make_header(OP_NONINC, 13'd2, 3'd5, 12'd3584), 1'b1);
        send_beat('1, 1'b0);
        send_beat(32'h8000_0001, 1'b0);
        // A zero count opens nothing.
        send_beat(make_header(OP_INC, 13'd0, 3'd7, 12'd100), 1'b0);
        // Immediates with the largest and the smallest value.
        send_beat(make_header(OP_IMMD, 13'h1FFF, 3'd7, 12'hFFF), 1'b1);
        send_beat(make_header(OP_IMMD, 13'h0000, SUB_3D, 12'h000), 1'b0);
        // End segment on the last word skips nothing; elsewhere it drops the entry.
        send_beat('1, 1'b1);
        send_beat({OP_ENDSEG, 29'h0}, 1'b0);
        send_beat(make_header(OP_INC, 13'd5, SUB_3D, 12'd10), 1'b0);
        send_beat(make_header(OP_IMMD, 13'd7, SUB_3D, 12'd10), 1'b1);
        // Unsupported headers, with and without the rest of the entry behind them.
        send_beat({OP_RSVD2, 29'h0ABC_DEF0}, 1'b0);
        send_beat(make_header(OP_IMMD, 13'd1, SUB_2D, 12'd3), 1'b1);
        send_beat({OP_RSVD6, 29'h1FFF_FFFF}, 1'b1);
        send_beat({OP_GRP0, 10'h000, 3'd0, 16'h0001}, 1'b1);
        send_beat(make_header(OP_IMMD, 13'd9, 3'd1, 12'd4000), 1'b0);
    endtask

    // Several class boundaries, the extremes and an overlap of the two ranges among them.
    task automatic test_class_ranges();
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] e;
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: begin h = 12'd0;    e = 12'd0;    end
                1: begin h = 12'd4095; e = 12'd4095; end
                2: begin h = 12'd0;    e = 12'd4095; end
                3: begin h = 12'd4095; e = 12'd0;    end
                4: begin h = 12'd3000; e = 12'd100;  end
                5: begin h = 12'd1;    e = 12'd2;    end
                default: begin h = CFG_W'($urandom); e = CFG_W'($urandom); end
            endcase
            wait_idle();
            write_cfg(CFG_HOST_REG_COUNT, h);
            write_cfg(CFG_ENGINE_END, e);
            run_beats(35);
        end
        wait_idle();
        write_cfg(CFG_HOST_REG_COUNT, HOST_REG_COUNT_RESET);
        write_cfg(CFG_ENGINE_END, ENGINE_END_RESET);
    endtask

    // The output holds off for a long time while a long method keeps coming, so the
    // block fills up and has to stall its input.
    task automatic test_output_hold();
        wait_idle();
        hold_cycles = 250;
        send_beat(make_header(OP_INC, 13'd59, SUB_3D, 12'd40), 1'b0);
        repeat (59) send_beat(rand_data(), rand_last());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        run_beats(600);
    endtask

    // Back-to-back beats with neither side idling.
    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_beats(100);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_word       = '0;
        i_entry_last = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_HOST_REG_COUNT;
        i_cfg_data   = '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        // Model state as the block comes out of reset.
        pend_count   = '0;
        call_addr    = '0;
        open_sub     = '0;
        addr_mode    = MODE_INC;
        skipping     = 1'b0;
        host_limit   = HOST_REG_COUNT_RESET;
        engine_limit = ENGINE_END_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_class_ranges();
        test_output_hold();
        test_random_traffic();
        test_steady_stream();
        wait_idle();

        if (expected_calls.size() != 0) begin
            $display("%0d expected calls never arrived", expected_calls.size());
            fail_count += expected_calls.size();
        end
        if (fail_count == 0) begin
            $display("** pushbuffer_method_decoder: PASSED **");
        end else begin
            $display("** pushbuffer_method_decoder: FAILED **");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every gap and stall at its longest.
    initial begin
        #(12 * 500000);
        $display("timeout waiting for the decoder");
        $display("** pushbuffer_method_decoder: FAILED **");
        $finish;
    end

endmodule
